@@ rtl/assert_macros.svh @@
// assertion macros for the rtl files
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/lru_pkg.sv @@
// constants for the lru page replacement block
// no dependencies
package lru_pkg;

  localparam int MAX_FRAMES_DEF = 8;
  localparam int PAGE_BITS_DEF  = 16;
  localparam int FRAME_W        = 3;
  localparam int CFG_W          = 4;
  localparam int FAULT_W        = 32;
  localparam logic [CFG_W-1:0]   FRAMES_RESET = 4'd3;
  localparam logic [FAULT_W-1:0] FAULT_MAX    = {FAULT_W{1'b1}};

endpackage

@@ rtl/lru_page_replacement_top.sv @@
// lru page replacement: the whole block in one module
// depends on lru_pkg and assert_macros.svh
//
// usage
//   in_*  : one page reference per transfer, page number in in_tdata
//   out_* : one result per reference: hit flag, frame, evicted page and the
//           saturating fault total
//   cfg_* : frames_in_use, written while the block is idle; 0 acts as 1 and
//           values above MAX_FRAMES act as MAX_FRAMES
// timing
//   the reference sits in an input register; the frame search, victim
//   choice and rank update are one pass of parallel compares that writes
//   the result register, which drives out_tvalid
//   one reference per cycle sustained while out_tready is high, with every
//   frame tag compared in parallel against the registered page
// reset
//   all frames empty, ranks and fault total zero, frames_in_use 3
// stall
//   when out_tready is low the result holds and one more reference waits
//   in the input register; in_tready then falls until the result is taken
`include "assert_macros.svh"

module lru_page_replacement_top #(
  parameter int MAX_FRAMES = lru_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = lru_pkg::PAGE_BITS_DEF,
  localparam int IN_W  = ((PAGE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((PAGE_BITS + 37 + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [lru_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_W-1:0]          in_tdata,   // page
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_W-1:0]         out_tdata   // hit, frame, evicted_valid, evicted_page, fault_count
);
  import lru_pkg::*;

  localparam int FW = $clog2(MAX_FRAMES);
  localparam int RW = $clog2(MAX_FRAMES);
  localparam logic [RW-1:0] RANK_MAX = RW'(MAX_FRAMES - 1);

  logic [CFG_W-1:0]     cfg_frames_r;
  logic                 s1_valid_r, s1_valid_nxt;
  logic [PAGE_BITS-1:0] s1_page_r;

  logic [PAGE_BITS-1:0] pages_r [MAX_FRAMES];
  logic [PAGE_BITS-1:0] pages_nxt [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_r, valid_nxt;
  logic [RW-1:0]        rank_r [MAX_FRAMES];
  logic [RW-1:0]        rank_nxt [MAX_FRAMES];
  logic [FAULT_W-1:0]   fault_r, fault_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r, out_ev_valid_r;
  logic [FRAME_W-1:0]   out_frame_r;
  logic [PAGE_BITS-1:0] out_ev_page_r;

  logic                 in_fire, advance, load;
  logic [MAX_FRAMES-1:0] part, match, empty, oldest;
  logic                 found, has_empty;
  logic [FW-1:0]        f_hit, f_empty, f_victim, f_sel;
  logic [RW-1:0]        limit;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;
  assign load      = s1_valid_r && advance;

  // frame search, empty search and victim choice
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      part[i]  = (i == 0) || (i < int'(cfg_frames_r));
      match[i] = part[i] && valid_r[i] && (pages_r[i] == s1_page_r);
      empty[i] = part[i] && !valid_r[i];
      oldest[i] = part[i];
      for (int j = 0; j < MAX_FRAMES; j++) begin
        if (part[j] && (rank_r[j] > rank_r[i])) begin
          oldest[i] = 1'b0;
        end
      end
    end
    found     = |match;
    has_empty = |empty;
    f_hit    = '0;
    f_empty  = '0;
    f_victim = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        f_hit = FW'(i);
      end
      if (empty[i]) begin
        f_empty = FW'(i);
      end
      if (oldest[i]) begin
        f_victim = FW'(i);
      end
    end
    priority if (found) begin
      f_sel = f_hit;
    end else if (has_empty) begin
      f_sel = f_empty;
    end else begin
      f_sel = f_victim;
    end
    limit = rank_r[f_sel];
  end

  // state update
  always_comb begin
    pages_nxt     = pages_r;
    valid_nxt     = valid_r;
    rank_nxt      = rank_r;
    fault_nxt     = fault_r;
    out_valid_nxt = out_valid_r;
    s1_valid_nxt  = s1_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      s1_valid_nxt  = 1'b0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        if (part[i] && (FW'(i) != f_sel) && valid_r[i] && (rank_r[i] != RANK_MAX) &&
            (!found || (rank_r[i] < limit))) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
      rank_nxt[f_sel] = '0;
      if (!found) begin
        pages_nxt[f_sel] = s1_page_r;
        valid_nxt[f_sel] = 1'b1;
        if (fault_r != FAULT_MAX) begin
          fault_nxt = fault_r + 1'b1;
        end
      end
    end
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_frames_r <= FRAMES_RESET;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      valid_r      <= '0;
      fault_r      <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        cfg_frames_r <= cfg_wr_data;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      fault_r     <= fault_nxt;
      rank_r      <= rank_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pages_r <= pages_nxt;
    if (in_fire) begin
      s1_page_r <= in_tdata[PAGE_BITS-1:0];
    end
    if (load) begin
      out_hit_r      <= found;
      out_frame_r    <= FRAME_W'(f_sel);
      out_ev_valid_r <= !found && !has_empty;
      out_ev_page_r  <= (!found && !has_empty) ? pages_r[f_victim] : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({fault_r, out_ev_page_r, out_ev_valid_r, out_frame_r, out_hit_r});

  `ASSERT_NEVER(a_hit_no_evict, out_valid_r && out_hit_r && out_ev_valid_r, "hit with eviction")
  `ASSERT_CLK(a_fault_step, load && !found |=> (fault_r == $past(fault_r) + 1'b1) || ($past(fault_r) == FAULT_MAX), "fault count not advanced")
  `ASSERT_CLK(a_frame_filled, load |=> valid_r[$past(f_sel)] && (rank_r[$past(f_sel)] == '0), "chosen frame not resident and newest")

endmodule
